### rtl/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// types, codes and update functions shared by the blinds motor controller
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int DATA_W      = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DATA_W-1:0] KEEP_TIME_RESET  = 16'd30000;
    localparam logic [DATA_W-1:0] PRESS_TIME_RESET = 16'd1000;
    localparam logic [DATA_W-1:0] REPLY_FILL       = 16'h00F0;
    localparam int                REPLY_UP_SHIFT   = 12;
    localparam int                REPLY_DOWN_SHIFT = 8;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_PRESS = 2'd1,
        MODE_ON    = 2'd2,
        MODE_KEEP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CMD_UP_FULL    = 3'd0,
        CMD_UP_VALUE   = 3'd1,
        CMD_DOWN_FULL  = 3'd2,
        CMD_DOWN_VALUE = 3'd3,
        CMD_UP_KEY     = 3'd4,
        CMD_DOWN_KEY   = 3'd5,
        CMD_GET_STATE  = 3'd6
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_KEEP_TIME  = 1'd0,
        CFG_PRESS_TIME = 1'd1
    } cfg_reg_t;

    // request type on the input channel
    localparam logic REQ_TICK = 1'b0;

    // debounce window outcome for the current tick
    typedef struct packed {
        logic done;
        logic up_hit;
        logic down_hit;
    } win_t;

    // per-direction service result
    typedef struct packed {
        mode_t             mode;
        logic              relay;
        logic [DATA_W-1:0] timer_start;
        logic [DATA_W-1:0] run_length;
    } serve_t;

    // modes and next relay levels seen by the output stage
    typedef struct packed {
        mode_t up_mode;
        mode_t down_mode;
        logic  up_relay_next;
        logic  down_relay_next;
    } dir_status_t;

    function automatic mode_t debounce(mode_t mode, logic hit);
        mode_t r;
        if (mode == MODE_KEEP) begin
            r = MODE_KEEP;
        end else if (hit) begin
            r = (mode == MODE_OFF) ? MODE_PRESS : MODE_ON;
        end else begin
            r = MODE_OFF;
        end
        return r;
    endfunction

    function automatic serve_t serve(
        mode_t             mode,
        mode_t             other,
        logic              relay,
        logic [DATA_W-1:0] timer_start,
        logic [DATA_W-1:0] run_length,
        logic [DATA_W-1:0] tick_now,
        logic [DATA_W-1:0] press_time,
        logic [DATA_W-1:0] keep_time
    );
        serve_t            r;
        logic [DATA_W-1:0] diff;
        r.mode        = mode;
        r.relay       = relay;
        r.timer_start = timer_start;
        r.run_length  = run_length;
        diff          = tick_now - timer_start;
        case (mode)
            MODE_PRESS: begin
                r.timer_start = tick_now;
                r.mode        = MODE_ON;
            end
            MODE_ON: begin
                if (diff >= press_time) begin
                    r.timer_start = tick_now;
                    r.relay       = 1'b1;
                    r.mode        = MODE_KEEP;
                    r.run_length  = keep_time;
                end
            end
            MODE_KEEP: begin
                // opposite direction active stops the run straight away
                if (other != MODE_OFF) begin
                    r.relay = 1'b0;
                    r.mode  = MODE_OFF;
                end else if (diff >= run_length) begin
                    r.timer_start = tick_now;
                    r.relay       = 1'b0;
                    r.mode        = MODE_OFF;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/bmc_window.sv
// ----------------------------------------------------------------------------
// bmc_window
// debounce window: sample counters and window position for both buttons
// ----------------------------------------------------------------------------
module bmc_window #(
    parameter int WINDOW_LIMIT    = 50,
    parameter int PRESS_THRESHOLD = 10
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tick_en,
    input  logic            up_level,
    input  logic            down_level,
    output bmc_pkg::win_t   win
);

    localparam int CW = $clog2(WINDOW_LIMIT + 2);

    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] up_cnt_reg, up_cnt_next;
    logic [CW-1:0] down_cnt_reg, down_cnt_next;
    logic [CW-1:0] pos_inc, up_inc, down_inc;

    always_comb begin
        pos_inc  = pos_reg + CW'(1);
        up_inc   = up_cnt_reg + CW'(up_level);
        down_inc = down_cnt_reg + CW'(down_level);

        win.done     = int'(pos_inc) > WINDOW_LIMIT;
        win.up_hit   = int'(up_inc) > PRESS_THRESHOLD;
        win.down_hit = int'(down_inc) > PRESS_THRESHOLD;

        pos_next      = pos_reg;
        up_cnt_next   = up_cnt_reg;
        down_cnt_next = down_cnt_reg;
        if (tick_en) begin
            if (win.done) begin
                pos_next      = '0;
                up_cnt_next   = '0;
                down_cnt_next = '0;
            end else begin
                pos_next      = pos_inc;
                up_cnt_next   = up_inc;
                down_cnt_next = down_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            up_cnt_reg   <= '0;
            down_cnt_reg <= '0;
        end else begin
            pos_reg      <= pos_next;
            up_cnt_reg   <= up_cnt_next;
            down_cnt_reg <= down_cnt_next;
        end
    end

endmodule

### rtl/bmc_dir_ctrl.sv
// ----------------------------------------------------------------------------
// bmc_dir_ctrl
// direction modes, run timer, relays, commands and settings registers
// ----------------------------------------------------------------------------
module bmc_dir_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bmc_pkg::DATA_W-1:0]        cfg_wr_data,
    input  logic                              item_en,
    input  logic                              is_tick,
    input  bmc_pkg::win_t                     win,
    input  logic [2:0]                        command_code,
    input  logic [bmc_pkg::DATA_W-1:0]        command_value,
    output bmc_pkg::dir_status_t              status
);

    logic [bmc_pkg::DATA_W-1:0] keep_time_reg, press_time_reg;
    logic [bmc_pkg::DATA_W-1:0] tick_reg, tick_next;
    logic [bmc_pkg::DATA_W-1:0] ts_reg, ts_next;
    logic [bmc_pkg::DATA_W-1:0] rl_reg, rl_next;
    bmc_pkg::mode_t             up_mode_reg, up_mode_next;
    bmc_pkg::mode_t             down_mode_reg, down_mode_next;
    logic                       up_relay_reg, up_relay_next;
    logic                       down_relay_reg, down_relay_next;

    // values after the tick or command, before the service pass
    logic [bmc_pkg::DATA_W-1:0] tick_c, ts_c, rl_c, run_len;
    bmc_pkg::mode_t             up_c, down_c;
    logic                       up_rel_c, down_rel_c;
    bmc_pkg::serve_t            sv_up, sv_down;

    always_comb begin
        tick_c     = tick_reg;
        ts_c       = ts_reg;
        rl_c       = rl_reg;
        up_c       = up_mode_reg;
        down_c     = down_mode_reg;
        up_rel_c   = up_relay_reg;
        down_rel_c = down_relay_reg;
        run_len    = (command_code[0]) ? command_value : keep_time_reg;

        if (is_tick) begin
            tick_c = tick_reg + bmc_pkg::DATA_W'(1);
            if (win.done) begin
                up_c   = bmc_pkg::debounce(up_mode_reg, win.up_hit);
                down_c = bmc_pkg::debounce(down_mode_reg, win.down_hit);
            end
        end else begin
            unique case (command_code)
                bmc_pkg::CMD_UP_FULL, bmc_pkg::CMD_UP_VALUE: begin
                    down_rel_c = 1'b0;
                    if (down_mode_reg != bmc_pkg::MODE_OFF) begin
                        down_c = bmc_pkg::MODE_OFF;
                    end else begin
                        up_rel_c = 1'b1;
                        up_c     = bmc_pkg::MODE_KEEP;
                        rl_c     = run_len;
                        ts_c     = tick_reg;
                    end
                end
                bmc_pkg::CMD_DOWN_FULL, bmc_pkg::CMD_DOWN_VALUE: begin
                    up_rel_c = 1'b0;
                    if (up_mode_reg != bmc_pkg::MODE_OFF) begin
                        up_c = bmc_pkg::MODE_OFF;
                    end else begin
                        down_rel_c = 1'b1;
                        down_c     = bmc_pkg::MODE_KEEP;
                        rl_c       = run_len;
                        ts_c       = tick_reg;
                    end
                end
                bmc_pkg::CMD_UP_KEY: begin
                    down_rel_c = 1'b0;
                    if (down_mode_reg != bmc_pkg::MODE_OFF) begin
                        down_c = bmc_pkg::MODE_OFF;
                    end else if (command_value != '0) begin
                        up_rel_c = 1'b1;
                    end else if (up_mode_reg != bmc_pkg::MODE_KEEP) begin
                        up_rel_c = 1'b0;
                    end
                end
                bmc_pkg::CMD_DOWN_KEY: begin
                    up_rel_c = 1'b0;
                    if (up_mode_reg != bmc_pkg::MODE_OFF) begin
                        up_c = bmc_pkg::MODE_OFF;
                    end else if (command_value != '0) begin
                        down_rel_c = 1'b1;
                    end else if (down_mode_reg != bmc_pkg::MODE_KEEP) begin
                        down_rel_c = 1'b0;
                    end
                end
                default: begin
                    // state query and unused code change nothing here
                end
            endcase
        end

        // service pass: up first, down sees the updated up mode and timer
        sv_up = bmc_pkg::serve(up_c, down_c, up_rel_c, ts_c, rl_c, tick_c,
                               press_time_reg, keep_time_reg);
        sv_down = bmc_pkg::serve(down_c, sv_up.mode, down_rel_c, sv_up.timer_start,
                                 sv_up.run_length, tick_c, press_time_reg, keep_time_reg);

        tick_next       = tick_c;
        ts_next         = sv_down.timer_start;
        rl_next         = sv_down.run_length;
        up_mode_next    = sv_up.mode;
        down_mode_next  = sv_down.mode;
        up_relay_next   = sv_up.relay;
        down_relay_next = sv_down.relay;

        status.up_mode         = up_mode_reg;
        status.down_mode       = down_mode_reg;
        status.up_relay_next   = up_relay_next;
        status.down_relay_next = down_relay_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_time_reg  <= bmc_pkg::KEEP_TIME_RESET;
            press_time_reg <= bmc_pkg::PRESS_TIME_RESET;
            tick_reg       <= '0;
            ts_reg         <= '0;
            rl_reg         <= '0;
            up_mode_reg    <= bmc_pkg::MODE_OFF;
            down_mode_reg  <= bmc_pkg::MODE_OFF;
            up_relay_reg   <= 1'b0;
            down_relay_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    bmc_pkg::CFG_KEEP_TIME:  keep_time_reg  <= cfg_wr_data;
                    bmc_pkg::CFG_PRESS_TIME: press_time_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (item_en) begin
                tick_reg       <= tick_next;
                ts_reg         <= ts_next;
                rl_reg         <= rl_next;
                up_mode_reg    <= up_mode_next;
                down_mode_reg  <= down_mode_next;
                up_relay_reg   <= up_relay_next;
                down_relay_reg <= down_relay_next;
            end
        end
    end

endmodule

### rtl/blinds_motor_controller.sv
// ----------------------------------------------------------------------------
// blinds_motor_controller
// up/down relay control for a blinds motor with button debounce and commands
// ----------------------------------------------------------------------------
// Every request is either a tick carrying the sampled button levels or a
// command, and each one yields exactly one result carrying the relay drive
// after the request and, for a state query, the state word. A request is
// handled combinationally: the whole update of the small mode, timer and
// debounce registers sits between the state and result registers, so a new
// request can be accepted every cycle and the result appears on the m_ side
// the cycle after acceptance. The only thing that holds requests back is a
// result waiting in the output register while m_ready is low. The user must
// write keep_time and press_time settings through the cfg_ port only while
// the block is idle (not enforced here); they reset to 30000 and 1000 ticks.
// ----------------------------------------------------------------------------
module blinds_motor_controller #(
    parameter int WINDOW_LIMIT    = 50,
    parameter int PRESS_THRESHOLD = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // settings write port
    input  logic                             cfg_wr_en,
    input  logic [bmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bmc_pkg::DATA_W-1:0]       cfg_wr_data,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic                             s_button_up_level,
    input  logic                             s_button_down_level,
    input  logic                             s_reed_closed,
    input  logic [2:0]                       s_command_code,
    input  logic [bmc_pkg::DATA_W-1:0]       s_command_value,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_relay_up,
    output logic                             m_relay_down,
    output logic                             m_reply_valid,
    output logic [bmc_pkg::DATA_W-1:0]       m_reply_word
);

    logic                       accept;
    logic                       tick_en;
    logic                       is_tick;
    logic                       reply_valid;
    logic [bmc_pkg::DATA_W-1:0] reply_word;
    bmc_pkg::win_t              win;
    bmc_pkg::dir_status_t       status;

    logic                       m_valid_reg, m_valid_next;
    logic                       relay_up_reg, relay_down_reg;
    logic                       reply_valid_reg;
    logic [bmc_pkg::DATA_W-1:0] reply_word_reg;

    // the result register frees up as soon as its content is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_tick = (s_req_type == bmc_pkg::REQ_TICK);
    assign tick_en = accept && is_tick;

    bmc_window #(
        .WINDOW_LIMIT    (WINDOW_LIMIT),
        .PRESS_THRESHOLD (PRESS_THRESHOLD)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (tick_en),
        .up_level   (s_button_up_level),
        .down_level (s_button_down_level),
        .win        (win)
    );

    bmc_dir_ctrl u_dir_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .item_en       (accept),
        .is_tick       (is_tick),
        .win           (win),
        .command_code  (s_command_code),
        .command_value (s_command_value),
        .status        (status)
    );

    // state word reports the modes as they stood before the request
    always_comb begin
        reply_valid = !is_tick && (s_command_code == bmc_pkg::CMD_GET_STATE);
        reply_word  = '0;
        if (reply_valid) begin
            reply_word = (bmc_pkg::DATA_W'(status.up_mode) << bmc_pkg::REPLY_UP_SHIFT)
                       | (bmc_pkg::DATA_W'(status.down_mode) << bmc_pkg::REPLY_DOWN_SHIFT)
                       | bmc_pkg::REPLY_FILL
                       | bmc_pkg::DATA_W'(s_reed_closed);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, loaded only on acceptance
    always_ff @(posedge aclk) begin
        if (accept) begin
            relay_up_reg    <= status.up_relay_next;
            relay_down_reg  <= status.down_relay_next;
            reply_valid_reg <= reply_valid;
            reply_word_reg  <= reply_word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_relay_up    = relay_up_reg;
    assign m_relay_down  = relay_down_reg;
    assign m_reply_valid = reply_valid_reg;
    assign m_reply_word  = reply_word_reg;

    // a waiting result must block new requests
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request accepted while result stalled");

    // result register empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // state word carries its fixed fill bits
    a_reply_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reply_valid) |-> (m_reply_word[7:4] == 4'hF))
        else $error("state word fill bits wrong");

    // no state word without a query
    a_reply_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_reply_valid) |-> (m_reply_word == '0))
        else $error("state word present without a query");

    // an accepted request always leaves a result behind
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

endmodule
